// ===== hdl/gdad_pkg.sv =====
// Shared types, constants and the month-length function for the date adder.
// No dependencies; imported by the controller, the datapath and the top level.
package gdad_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int STAT_W  = 2;

  localparam logic [YEAR_W-1:0]  MAX_YEAR = 14'd9999;
  localparam logic [MONTH_W-1:0] DEC      = 4'd12;
  localparam logic [MONTH_W-1:0] JAN      = 4'd1;

  // floor(y / 100) = (y * 5243) >> 19 holds for every 14-bit y
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam int          PROD_W       = YEAR_W + 13;
  localparam int          QUOT_W       = PROD_W - DIV100_SHIFT;
  localparam logic [6:0]  CENT         = 7'd100;
  localparam logic [6:0]  CENT_LAST    = 7'd99;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MONTH = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic bad_month;
    logic bad_year;
    logic fits;
    logic wrap_ovf;
  } sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = 5'd31;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/gregorian_date_add_days.sv =====
// Gregorian date plus a day count: one month length subtracted per walk cycle.
// The controller steps through load, leap-counter setup and the month walk, and
// out_valid is registered from the finish command. A new transaction is taken in
// the out_valid cycle, so no new date is accepted while the month walk runs.
// Synchronous active-low reset returns to idle.
// Results are strobed for one cycle; the receiver cannot stall.
module gregorian_date_add_days #(
  parameter int ADD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gdad_pkg::DAY_W-1:0]    in_start_day,
  input  logic [gdad_pkg::MONTH_W-1:0]  in_start_month,
  input  logic [gdad_pkg::YEAR_W-1:0]   in_start_year,
  input  logic [ADD_BITS-1:0]           in_days_to_add,
  output logic                          out_valid,
  output logic [gdad_pkg::DAY_W-1:0]    out_result_day,
  output logic [gdad_pkg::MONTH_W-1:0]  out_result_month,
  output logic [gdad_pkg::YEAR_W-1:0]   out_result_year,
  output logic [gdad_pkg::STAT_W-1:0]   out_status
);
  import gdad_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gdad_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  gdad_dpath #(
    .ADD_BITS (ADD_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_start_day     (in_start_day),
    .in_start_month   (in_start_month),
    .in_start_year    (in_start_year),
    .in_days_to_add   (in_days_to_add),
    .out_valid        (out_valid),
    .out_result_day   (out_result_day),
    .out_result_month (out_result_month),
    .out_result_year  (out_result_year),
    .out_status       (out_status)
  );

endmodule

// ===== hdl/gdad_ctrl.sv =====
// Sequencer for the date adder: load, leap-counter setup, month walk, finish.
// Depends on gdad_pkg for the command and status structs.
module gdad_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  gdad_pkg::sts_t sts,
  output gdad_pkg::cmd_t cmd
);
  import gdad_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PREP = 3'b010,
    S_WALK = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   walk_end;

  assign walk_end = sts.bad_month | sts.bad_year | sts.fits | sts.wrap_ovf;
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        // stop on a bad start, on a fitting day, or at the year limit
        if (walk_end) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.prep, cmd.step, cmd.finish}))
    else $error("more than one datapath command at once");

  a_load_prep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.prep)
    else $error("load not followed by leap setup");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !busy)
    else $error("busy still high after finish");

  a_step_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !sts.fits && !sts.bad_month && !sts.bad_year)
    else $error("month step taken although the walk should end");

endmodule

// ===== hdl/gdad_dpath.sv =====
// Datapath of the date adder: day, month, year and leap counters, output register.
// Depends on gdad_pkg for types, constants and the month-length function.
module gdad_dpath #(
  parameter int ADD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gdad_pkg::cmd_t                     cmd,
  output gdad_pkg::sts_t                     sts,
  input  logic [gdad_pkg::DAY_W-1:0]         in_start_day,
  input  logic [gdad_pkg::MONTH_W-1:0]       in_start_month,
  input  logic [gdad_pkg::YEAR_W-1:0]        in_start_year,
  input  logic [ADD_BITS-1:0]                in_days_to_add,
  output logic                               out_valid,
  output logic [gdad_pkg::DAY_W-1:0]         out_result_day,
  output logic [gdad_pkg::MONTH_W-1:0]       out_result_month,
  output logic [gdad_pkg::YEAR_W-1:0]        out_result_year,
  output logic [gdad_pkg::STAT_W-1:0]        out_status
);
  import gdad_pkg::*;

  localparam int SUM_W = ADD_BITS + 1;

  logic [SUM_W-1:0]   day_r;
  logic [MONTH_W-1:0] month_r;
  logic [YEAR_W-1:0]  year_r;
  logic [PROD_W-1:0]  prod_r;
  logic [6:0]         c100_r;
  logic [1:0]         cen_r;

  logic               out_valid_r;
  logic [DAY_W-1:0]   out_day_r;
  logic [MONTH_W-1:0] out_month_r;
  logic [YEAR_W-1:0]  out_year_r;
  logic [STAT_W-1:0]  out_status_r;

  logic [QUOT_W-1:0]  quot;
  logic [YEAR_W-1:0]  cent_part;
  logic               leap;
  logic [DAY_W-1:0]   mlen;
  status_t            code;

  assign quot      = prod_r[PROD_W-1:DIV100_SHIFT];
  assign cent_part = YEAR_W'(quot * CENT);

  // Gregorian rule from year mod 100 and century mod 4
  assign leap = (c100_r == 7'd0) ? (cen_r == 2'd0) : (year_r[1:0] == 2'b00);
  assign mlen = month_len(month_r, leap);

  assign sts.bad_month = (month_r == 4'd0) || (month_r > DEC);
  assign sts.bad_year  = (year_r > MAX_YEAR);
  assign sts.fits      = (day_r <= SUM_W'(mlen));
  assign sts.wrap_ovf  = !sts.fits && (month_r == DEC) && (year_r >= MAX_YEAR);

  always_comb begin
    if (sts.bad_month) begin
      code = ST_BAD_MONTH;
    end else if (sts.bad_year || sts.wrap_ovf) begin
      code = ST_OVERFLOW;
    end else begin
      code = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r   <= SUM_W'(in_start_day) + SUM_W'(in_days_to_add);
      month_r <= in_start_month;
      year_r  <= in_start_year;
      prod_r  <= PROD_W'(in_start_year) * PROD_W'(DIV100_MUL);
    end
    if (cmd.prep) begin
      c100_r <= 7'(year_r - cent_part);
      cen_r  <= quot[1:0];
    end
    if (cmd.step) begin
      day_r <= day_r - SUM_W'(mlen);
      if (month_r == DEC) begin
        // wrap to January and advance the year counters
        month_r <= JAN;
        year_r  <= year_r + 14'd1;
        if (c100_r == CENT_LAST) begin
          c100_r <= 7'd0;
          cen_r  <= cen_r + 2'd1;
        end else begin
          c100_r <= c100_r + 7'd1;
        end
      end else begin
        month_r <= month_r + 4'd1;
      end
    end
    if (cmd.finish) begin
      out_status_r <= code;
      if (code == ST_OK) begin
        out_day_r   <= day_r[DAY_W-1:0];
        out_month_r <= month_r;
        out_year_r  <= year_r;
      end else begin
        out_day_r   <= '0;
        out_month_r <= '0;
        out_year_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_day   = out_day_r;
  assign out_result_month = out_month_r;
  assign out_result_year  = out_year_r;
  assign out_status       = out_status_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_result_day == '0) && (out_result_month == '0) && (out_result_year == '0))
    else $error("nonzero date reported with error status");

  a_ok_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |->
      (out_result_month != 4'd0) && (out_result_month <= DEC))
    else $error("month out of range on a good result");

  a_step_month: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (month_r >= JAN) && (month_r <= DEC))
    else $error("month left 1..12 during the walk");

endmodule

// ===== test/gregorian_date_add_days_test.sv =====
// Self-checking testbench for gregorian_date_add_days: queue-fed driver, strobe monitor.
// Predicts each date sum with a local month walk; depends only on gdad_pkg and the block.
`timescale 1ns / 1ps

module gregorian_date_add_days_test;
  import gdad_pkg::*;

  localparam int ADD_W = 16;

  typedef struct {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [ADD_W-1:0]   add;
    bit                 drain;  // hold off until every pending date has come back
  } date_item_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    status_t            status;
  } date_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [DAY_W-1:0]    in_start_day = '0;
  logic [MONTH_W-1:0]  in_start_month = '0;
  logic [YEAR_W-1:0]   in_start_year = '0;
  logic [ADD_W-1:0]    in_days_to_add = '0;
  logic                out_valid;
  logic [DAY_W-1:0]    out_result_day;
  logic [MONTH_W-1:0]  out_result_month;
  logic [YEAR_W-1:0]   out_result_year;
  logic [STAT_W-1:0]   out_status;

  date_item_t   pending_dates[$];
  date_result_t expected_dates[$];
  date_item_t   cur_date;
  date_result_t want_date;
  date_result_t got_date;
  int           n_sent = 0;
  int           n_errors = 0;

  gregorian_date_add_days #(.ADD_BITS(ADD_W)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_start_day     (in_start_day),
    .in_start_month   (in_start_month),
    .in_start_year    (in_start_year),
    .in_days_to_add   (in_days_to_add),
    .out_valid        (out_valid),
    .out_result_day   (out_result_day),
    .out_result_month (out_result_month),
    .out_result_year  (out_result_year),
    .out_status       (out_status)
  );

  always #2 clk = ~clk;

  // Walk month by month, subtracting each month's length, until the day fits.
  function automatic date_result_t add_days_to_date(date_item_t it);
    int unsigned  d;
    int unsigned  m;
    int unsigned  y;
    int unsigned  mlen;
    bit           fits;
    bit           leap;
    status_t      st;
    date_result_t r;
    d = it.day + it.add;
    m = it.month;
    y = it.year;
    st = ST_OK;
    fits = 1'b0;
    if (m < 1 || m > 12) begin
      st = ST_BAD_MONTH;
    end else if (y > MAX_YEAR) begin
      st = ST_OVERFLOW;
    end else begin
      while (!fits && st == ST_OK) begin
        leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        case (m)
          2:             mlen = leap ? 29 : 28;
          4, 6, 9, 11:   mlen = 30;
          default:       mlen = 31;
        endcase
        if (d <= mlen) begin
          fits = 1'b1;
        end else begin
          d = d - mlen;
          m = m + 1;
          if (m > 12) begin
            if (y >= MAX_YEAR) st = ST_OVERFLOW;
            else begin
              m = 1;
              y = y + 1;
            end
          end
        end
      end
    end
    if (st != ST_OK) begin
      d = 0;
      m = 0;
      y = 0;
    end
    r.day = d[DAY_W-1:0];
    r.month = m[MONTH_W-1:0];
    r.year = y[YEAR_W-1:0];
    r.status = st;
    return r;
  endfunction

  task automatic queue_date(input int d, input int m, input int y, input int a,
                            input bit drain = 1'b0);
    date_item_t it;
    it.day = d[DAY_W-1:0];
    it.month = m[MONTH_W-1:0];
    it.year = y[YEAR_W-1:0];
    it.add = a[ADD_W-1:0];
    it.drain = drain;
    pending_dates.push_back(it);
  endtask

  // Pick a day count: mostly short walks, a few spanning the full range.
  function automatic int pick_add();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(400);
    if (r < 85) return $urandom_range(4000);
    return $urandom_range(65535);
  endfunction

  // Driver: hold start until the block takes the transaction, then present the next one.
  always @(posedge clk) begin
    bit quiet;
    bit go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_dates.push_back(add_days_to_date(cur_date));
        n_sent++;
      end
      if (!(start && busy)) begin
        quiet = (n_sent >= 120 && n_sent < 180);
        go = pending_dates.size() > 0;
        if (go && pending_dates[0].drain && (start || expected_dates.size() != 0)) go = 1'b0;
        if (go && !quiet && $urandom_range(99) < 32) go = 1'b0;
        if (go) begin
          cur_date = pending_dates.pop_front();
          in_start_day <= cur_date.day;
          in_start_month <= cur_date.month;
          in_start_year <= cur_date.year;
          in_days_to_add <= cur_date.add;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expected date.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_date = '{out_result_day, out_result_month, out_result_year, status_t'(out_status)};
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected result day %0d month %0d year %0d status %0d", $time,
                 got_date.day, got_date.month, got_date.year, got_date.status);
        n_errors++;
      end else begin
        want_date = expected_dates.pop_front();
        if (got_date !== want_date) begin
          $display("%0t: mismatch expected %0d/%0d/%0d st %0d, actual %0d/%0d/%0d st %0d",
                   $time, want_date.day, want_date.month, want_date.year, want_date.status,
                   got_date.day, got_date.month, got_date.year, got_date.status);
          n_errors++;
        end
      end
    end
  end

  initial begin
    int r;
    int m;
    int y;
    int d;
    // directed: extremes, rollovers, leap rules, invalid month, year bounds
    queue_date(1, 1, 1, 0);
    queue_date(31, 12, 2023, 1);
    queue_date(28, 2, 2024, 1);
    queue_date(28, 2, 2023, 1);
    queue_date(28, 2, 1900, 1);
    queue_date(28, 2, 2000, 1);
    queue_date(28, 2, 0, 1);
    queue_date(0, 0, 0, 0);
    queue_date(15, 13, 2020, 10);
    queue_date(31, 15, 16383, 65535);
    queue_date(1, 6, 10000, 5, 1'b1);
    queue_date(1, 6, 16383, 0);
    queue_date(31, 12, 9999, 0);
    queue_date(31, 12, 9999, 1);
    queue_date(1, 1, 9999, 364);
    queue_date(1, 1, 9999, 365);
    queue_date(0, 3, 2021, 0);
    queue_date(31, 2, 2023, 0);
    queue_date(31, 4, 2022, 0);
    queue_date(31, 1, 1, 65535);
    queue_date(1, 1, 9800, 65535);
    queue_date(31, 12, 9900, 65535);
    for (int i = 0; i < 270; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        m = $urandom_range(3);
        m = (m == 0) ? 0 : 12 + m;
        queue_date($urandom_range(31), m, $urandom_range(16383), $urandom_range(65535));
      end else if (r < 14) begin
        queue_date($urandom_range(31), $urandom_range(1, 12), $urandom_range(16383, 10000),
                   $urandom_range(65535));
      end else if (r < 22) begin
        queue_date($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(9999, 9800),
                   $urandom_range(65535));
      end else begin
        d = ($urandom_range(99) < 5) ? $urandom_range(31) : $urandom_range(1, 31);
        y = ($urandom_range(99) < 30) ? $urandom_range(99) * 100 + $urandom_range(3)
                                      : $urandom_range(1, 9999);
        queue_date(d, $urandom_range(1, 12), y, pick_add(), i == 150);
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_dates.size() != 0 || start || expected_dates.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("** gregorian_date_add_days: PASSED **");
    end else begin
      $display("** gregorian_date_add_days: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("** gregorian_date_add_days: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gdad_pkg.sv
hdl/gdad_ctrl.sv
hdl/gdad_dpath.sv
hdl/gregorian_date_add_days.sv
test/gregorian_date_add_days_test.sv
